>>> rtl/core/assert_macros.svh
// concurrent assertion helpers, sampled on the rising clock edge, off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

>>> rtl/core/ssort_pkg.sv
package ssort_pkg;

   localparam int DEPTH     = 64;
   localparam int KEY_WIDTH = 32;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int TDATA_W   = 32;

endpackage

>>> rtl/core/shell_sort_halving_gaps.sv
// shell sort with halving gaps
// req channel: one key per request (req_tdata), req_tlast closes the set.
// loading accepts one request per cycle.
// keys after the first DEPTH of a set are dropped; every result of that set then
// carries rsp_tuser = 1 (overflow).
// after the closing request the set is sorted in place in a single-port-write,
// registered-read key memory: gaps n/2, n/4 .. 1, each a gapped insertion pass.
// each row of a pass reads its key, loads it while reading its neighbor, then
// compares and shifts once per larger neighbor, then places it in the gap left.
// rsp channel: sorted keys ascending, rsp_tlast on the final one. each result
// goes through memory read, output load and handshake, waiting while stalled.
// req_tready is high only while loading; a set occupies the block from its
// closing request until its last result is taken, so results of a set of n keys
// follow the closing request after the sort, each read after the previous is taken.
// a stalled receiver holds the output register and freezes the block.
// reset (synchronous, active high) empties the set and clears the overflow mark;
// memory contents are not cleared and need no clearing pass.
module shell_sort_halving_gaps (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ssort_pkg::TDATA_W-1:0]  req_tdata,   // [31:0] key
   input  logic                           req_tlast,   // last_in
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ssort_pkg::TDATA_W-1:0]  rsp_tdata,   // [31:0] sorted_key
   output logic                           rsp_tlast,   // last_out
   output logic                           rsp_tuser    // [0] overflow
);
   import ssort_pkg::*;

   typedef enum logic [2:0] {
      S_LOAD,
      S_ROW_RD,
      S_ROW_LD,
      S_CMP,
      S_PLACE,
      S_EMIT_RD,
      S_EMIT_LD,
      S_EMIT_WAIT
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 dropped_ff, dropped_in;
   logic [CNT_W-1:0]     gap_ff, gap_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [KEY_WIDTH-1:0] cur_ff, cur_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TDATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_user_ff, rsp_user_in;

   // key memory
   logic [KEY_WIDTH-1:0] key_mem [DEPTH];
   logic [KEY_WIDTH-1:0] rdata_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [KEY_WIDTH-1:0] mem_wdata;
   logic [ADDR_W-1:0]    mem_raddr;

   logic [CNT_W-1:0]     i_next, gap_half, pos_dn, k_next, n_new;
   logic                 room, row_end;

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign i_next   = i_ff + 1'b1;
   assign k_next   = k_ff + 1'b1;
   assign gap_half = gap_ff >> 1;
   assign pos_dn   = pos_ff - gap_ff;
   assign room     = (count_ff < CNT_W'(DEPTH));
   assign n_new    = room ? (count_ff + 1'b1) : count_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      gap_in       = gap_ff;
      i_in         = i_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[ADDR_W-1:0];
      mem_wdata    = KEY_WIDTH'(req_tdata);
      mem_raddr    = i_ff[ADDR_W-1:0];
      row_end      = 1'b0;

      unique case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               if (room) begin
                  mem_we   = 1'b1;
                  count_in = n_new;
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  gap_in = n_new >> 1;
                  i_in   = n_new >> 1;
                  k_in   = '0;
                  state_in = ((n_new >> 1) == '0) ? S_EMIT_RD : S_ROW_RD;
               end
            end
         end
         S_ROW_RD: begin
            mem_raddr = i_ff[ADDR_W-1:0];
            state_in  = S_ROW_LD;
         end
         S_ROW_LD: begin
            // i >= gap always holds, so the first neighbor exists
            cur_in    = rdata_ff;
            pos_in    = i_ff;
            mem_raddr = ADDR_W'(i_ff - gap_ff);
            state_in  = S_CMP;
         end
         S_CMP: begin
            mem_waddr = pos_ff[ADDR_W-1:0];
            mem_we    = 1'b1;
            if (rdata_ff > cur_ff) begin
               mem_wdata = rdata_ff;
               pos_in    = pos_dn;
               if (pos_dn >= gap_ff) begin
                  mem_raddr = ADDR_W'(pos_dn - gap_ff);
               end else begin
                  state_in = S_PLACE;
               end
            end else begin
               mem_wdata = cur_ff;
               row_end   = 1'b1;
            end
         end
         S_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[ADDR_W-1:0];
            mem_wdata = cur_ff;
            row_end   = 1'b1;
         end
         S_EMIT_RD: begin
            mem_raddr = k_ff[ADDR_W-1:0];
            state_in  = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = TDATA_W'(rdata_ff);
            rsp_last_in  = (k_next == count_ff);
            rsp_user_in  = dropped_ff;
            state_in     = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = S_LOAD;
               end else begin
                  k_in     = k_next;
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase

      // next row of this pass, next pass, or start emitting
      if (row_end) begin
         if (i_next < count_ff) begin
            i_in     = i_next;
            state_in = S_ROW_RD;
         end else if (gap_half != '0) begin
            gap_in   = gap_half;
            i_in     = gap_half;
            state_in = S_ROW_RD;
         end else begin
            k_in     = '0;
            state_in = S_EMIT_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gap_ff      <= gap_in;
      i_ff        <= i_in;
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= key_mem[mem_raddr];
   end

`include "assert_macros.svh"

   `ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `ASSERT_SAME(a_rsp_only_emit, clock, reset, rsp_valid_ff, state_ff == S_EMIT_WAIT)
   `ASSERT_SAME(a_cmp_in_range, clock, reset, state_ff == S_CMP,
                (pos_ff >= gap_ff) && (pos_ff < count_ff))
   `ASSERT_NEXT(a_set_cleared, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
                (count_ff == '0) && !dropped_ff && (state_ff == S_LOAD))

endmodule

>>> dv/tb_shell_sort_halving_gaps.sv
module tb_shell_sort_halving_gaps;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KW = ssort_pkg::TDATA_W;

   class sorted_set_board;
      typedef struct packed {
         logic [KW-1:0] key;
         logic          last;
         logic          ovf;
      } sorted_rsp_type;

      logic [KW-1:0]  set_keys[$];
      bit             keys_dropped;
      sorted_rsp_type sorted_keys_due[$];
      int             errors;

      function new();
         keys_dropped = 0;
         errors       = 0;
      endfunction

      // buffer one key; the closing request sorts the set and queues its results
      function void note_request(logic [KW-1:0] key, logic last);
         int             n;
         int             gap;
         int             i;
         int             pos;
         logic [KW-1:0]  cur;
         sorted_rsp_type r;
         if (set_keys.size() < ssort_pkg::DEPTH)
            set_keys.push_back(key);
         else
            keys_dropped = 1;
         if (!last)
            return;
         n = set_keys.size();
         for (gap = n / 2; gap > 0; gap = gap / 2) begin
            for (i = gap; i < n; i++) begin
               cur = set_keys[i];
               pos = i;
               while (pos >= gap && set_keys[pos - gap] > cur) begin
                  set_keys[pos] = set_keys[pos - gap];
                  pos -= gap;
               end
               set_keys[pos] = cur;
            end
         end
         for (i = 0; i < n; i++) begin
            r.key  = set_keys[i];
            r.last = (i == n - 1);
            r.ovf  = keys_dropped;
            sorted_keys_due.push_back(r);
         end
         set_keys.delete();
         keys_dropped = 0;
      endfunction

      function void check_result(logic [KW-1:0] key, logic last, logic ovf);
         sorted_rsp_type e;
         if (sorted_keys_due.size() == 0) begin
            $display("%0t: unexpected result key=%h last=%b ovf=%b", $time, key, last, ovf);
            errors++;
            return;
         end
         e = sorted_keys_due.pop_front();
         if (e.key !== key || e.last !== last || e.ovf !== ovf) begin
            $display("%0t: result mismatch expected key=%h last=%b ovf=%b actual key=%h last=%b ovf=%b",
                     $time, e.key, e.last, e.ovf, key, last, ovf);
            errors++;
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [KW-1:0] req_tdata;
   logic          req_tlast;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [KW-1:0] rsp_tdata;
   logic          rsp_tlast;
   logic          rsp_tuser;

   sorted_set_board board = new();
   bit calm         = 0;
   bit hold_pending = 0;

   shell_sort_halving_gaps dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_key(input logic [KW-1:0] key, input logic last);
      while (!calm && $urandom_range(0, 99) < 28) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_request(key, last);
      @(negedge clock);
   endtask

   function automatic logic [KW-1:0] random_key();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 7);
         1: return $urandom & ({KW{1'b1}} >> $urandom_range(0, KW - 1));
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_set(input int size);
      for (int i = 0; i < size; i++)
         send_key(random_key(), i == size - 1);
   endtask

   // receiver: random stalls, plus one long hold-off so the block backs up
   initial begin
      forever begin
         @(negedge clock);
         if (hold_pending && rsp_tvalid) begin
            hold_pending = 0;
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
         end
         rsp_tready <= (!calm && $urandom_range(0, 99) < 28) ? 1'b0 : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   initial begin
      int set_no;
      int sent;
      int size;
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single-key sets at both extremes
      send_key('0, 1'b1);
      send_key({KW{1'b1}}, 1'b1);
      // extremes mixed
      send_key({KW{1'b1}}, 1'b0);
      send_key('0, 1'b0);
      send_key(32'h8000_0000, 1'b0);
      send_key(32'h7fff_ffff, 1'b0);
      send_key(32'h1, 1'b1);
      // equal keys
      send_key(32'd5, 1'b0);
      send_key(32'd5, 1'b0);
      send_key(32'd3, 1'b0);
      send_key(32'd5, 1'b0);
      send_key(32'd3, 1'b1);
      // descending order
      for (int i = 7; i > 0; i--)
         send_key(i, i == 1);

      sent   = 19;
      set_no = 0;
      while (sent < 230) begin
         // no idling on either side around the overflow set
         calm = (set_no >= 5 && set_no <= 7);
         if (set_no == 3) begin
            // exactly full buffer, with the long receiver hold-off
            hold_pending = 1;
            size = ssort_pkg::DEPTH;
         end else if (set_no == 6) begin
            // buffer overflow, the closing key itself is dropped
            size = ssort_pkg::DEPTH + $urandom_range(1, 4);
         end else if ($urandom_range(0, 7) == 0) begin
            size = $urandom_range(13, 40);
         end else begin
            size = $urandom_range(1, 12);
         end
         send_random_set(size);
         sent += size;
         set_no++;
      end
      calm = 0;
      req_tvalid <= 1'b0;

      while (board.sorted_keys_due.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (board.errors == 0 && board.sorted_keys_due.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
